// ===== sv/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg: shared constants for the unix time calendar converter
// Pipeline depth, command codes, reciprocal constants and month tables.
// ----------------------------------------------------------------------------
package ucc_pkg;

    // register stages from an accepted beat to the result register
    localparam int unsigned PIPE_DEPTH = 10;

    typedef enum logic {
        CMD_TO_SECONDS = 1'b0,
        CMD_TO_DATE    = 1'b1
    } cmd_t;

    // reciprocal constants for division by constants
    localparam logic [31:0] MAG_DIV60  = 32'h8888_8889; // x/60 = (x*m) >> 37
    localparam logic [31:0] MAG_DIV3   = 32'hAAAA_AAAB; // x/3  = (x*m) >> 33
    localparam logic [10:0] MAG_DIV25  = 11'd1311;      // x/25 = (x*m) >> 15, x < 1024
    localparam logic [15:0] MAG_DIV1461 = 16'd45934;    // x/1461 = (x*m) >> 26
    localparam logic [16:0] MAG_DIV7   = 17'd74899;     // x/7  = (x*m) >> 19

    localparam logic [11:0] BASE_YEAR     = 12'd1970;
    localparam logic [11:0] CYCLE_YEAR    = 12'd1968;   // leap year starting the 4-year cycles
    localparam logic [15:0] CYCLE_OFFSET  = 16'd731;    // days from 1968-01-01 to 1970-01-01
    localparam logic [15:0] SKIP_LEAP_DAY = 16'd47541;  // days to 2100-03-01 (2100 not leap)
    localparam logic [19:0] LEAPS_TO_BASE = 20'd477;    // leap count of years up to 1969

    // days in the year before the first of month m (m of zero reads as january)
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/ucc_to_seconds.sv =====
// ----------------------------------------------------------------------------
// ucc_to_seconds: calendar fields to unix seconds
// Closed-form year and month day counts, then a 32-bit multiply-add,
// padded with delay stages to the common pipeline depth.
// ----------------------------------------------------------------------------
module ucc_to_seconds
    import ucc_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [11:0] cal_year,
    input  logic [3:0]  cal_month,
    input  logic [4:0]  cal_day,
    input  logic [4:0]  cal_hour,
    input  logic [5:0]  cal_minute,
    input  logic [5:0]  cal_second,
    output logic [31:0] seconds
);

    localparam int unsigned PAD = PIPE_DEPTH - 5;

    // stage 1 signals
    logic [11:0] yc;
    logic [11:0] yn;
    logic [21:0] q100_prod;
    logic [21:0] q400_prod;
    logic [21:0] y100_prod;
    logic [21:0] y400_prod;
    logic [9:0]  q4_reg;
    logic [5:0]  q100_reg;
    logic [3:0]  q400_reg;
    logic [11:0] yoff_reg;
    logic [5:0]  y100_reg;
    logic [3:0]  y400_reg;
    logic [11:0] year1_reg;
    logic [3:0]  month1_reg;
    logic [4:0]  day1_reg;
    logic [4:0]  hour1_reg;
    logic [5:0]  min1_reg;
    logic [5:0]  sec1_reg;

    // stage 2 signals
    logic [20:0] ydays_next;
    logic        leap_next;
    logic [20:0] ydays2_reg;
    logic        leap2_reg;
    logic [3:0]  last2_reg;
    logic [4:0]  day2_reg;
    logic [4:0]  hour2_reg;
    logic [5:0]  min2_reg;
    logic [5:0]  sec2_reg;

    // stage 3 to 5 signals
    logic [8:0]  mdays;
    logic [31:0] days3_reg;
    logic [16:0] extra3_reg;
    logic [31:0] prod4_reg;
    logic [16:0] extra4_reg;
    logic [31:0] total5_reg;
    logic [31:0] dly_reg [PAD];

    assign yc = (cal_year < BASE_YEAR) ? BASE_YEAR : cal_year;
    assign yn = yc - 12'd1;
    assign q100_prod = 22'(yn[11:2]) * 22'(MAG_DIV25);
    assign q400_prod = 22'(yn[11:4]) * 22'(MAG_DIV25);
    assign y100_prod = 22'(cal_year[11:2]) * 22'(MAG_DIV25);
    assign y400_prod = 22'(cal_year[11:4]) * 22'(MAG_DIV25);

    // stage 1: leap-year quotients of the clamped and the given year
    always_ff @(posedge aclk) begin
        if (en) begin
            q4_reg     <= yn[11:2];
            q100_reg   <= q100_prod[20:15];
            q400_reg   <= q400_prod[18:15];
            yoff_reg   <= yc - BASE_YEAR;
            y100_reg   <= y100_prod[20:15];
            y400_reg   <= y400_prod[18:15];
            year1_reg  <= cal_year;
            month1_reg <= cal_month;
            day1_reg   <= cal_day;
            hour1_reg  <= cal_hour;
            min1_reg   <= cal_minute;
            sec1_reg   <= cal_second;
        end
    end

    // stage 2: days of whole years and leap flag of the given year
    always_comb begin
        ydays_next = 21'(yoff_reg) * 21'd365 + 21'(q4_reg) - 21'(q100_reg)
                   + 21'(q400_reg) - 21'(LEAPS_TO_BASE);
        leap_next  = (year1_reg[1:0] == 2'd0)
                   && ((year1_reg != 12'(y100_reg) * 12'd100)
                       || (year1_reg == 12'(y400_reg) * 12'd400));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ydays2_reg <= ydays_next;
            leap2_reg  <= leap_next;
            last2_reg  <= (month1_reg > 4'd12) ? 4'd12 : month1_reg;
            day2_reg   <= day1_reg;
            hour2_reg  <= hour1_reg;
            min2_reg   <= min1_reg;
            sec2_reg   <= sec1_reg;
        end
    end

    // stage 3: day count and time-of-day seconds
    assign mdays = cum_days(last2_reg) + 9'((leap2_reg && last2_reg > 4'd2) ? 1 : 0);

    always_ff @(posedge aclk) begin
        if (en) begin
            days3_reg  <= 32'(ydays2_reg) + 32'(mdays) + 32'(day2_reg) - 32'd1;
            extra3_reg <= 17'(hour2_reg) * 17'd3600 + 17'(min2_reg) * 17'd60
                        + 17'(sec2_reg);
        end
    end

    // stage 4 and 5: scale days to seconds, add time of day
    always_ff @(posedge aclk) begin
        if (en) begin
            prod4_reg  <= days3_reg * 32'd86400;
            extra4_reg <= extra3_reg;
            total5_reg <= prod4_reg + 32'(extra4_reg);
        end
    end

    // delay line to the common depth
    always_ff @(posedge aclk) begin
        if (en) begin
            dly_reg[0] <= total5_reg;
            for (int i = 1; i < PAD; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign seconds = dly_reg[PAD-1];

endmodule

// ===== sv/ucc_to_date.sv =====
// ----------------------------------------------------------------------------
// ucc_to_date: unix seconds to calendar fields
// Reciprocal divisions split seconds into time of day and days, then a
// 4-year cycle decode gives year, month, day and weekday.
// ----------------------------------------------------------------------------
module ucc_to_date
    import ucc_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] epoch_seconds,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [2:0]  weekday
);

    logic [63:0] p1;
    logic [26:0] q1_reg;
    logic [5:0]  tlo1_reg;
    logic [26:0] t1_2_reg;
    logic [5:0]  sec2_reg;
    logic [63:0] p3;
    logic [20:0] q3_reg;
    logic [5:0]  t1lo3_reg;
    logic [5:0]  sec3_reg;
    logic [20:0] t2_4_reg;
    logic [5:0]  min4_reg;
    logic [5:0]  sec4_reg;
    logic [52:0] p5;
    logic [15:0] q5_reg;
    logic [4:0]  t2lo5_reg;
    logic [5:0]  min5_reg;
    logic [5:0]  sec5_reg;
    logic [15:0] days6_reg;
    logic [15:0] dc6_reg;
    logic [4:0]  hr6_reg;
    logic [5:0]  min6_reg;
    logic [5:0]  sec6_reg;
    logic [15:0] dp3;
    logic [31:0] pc;
    logic [32:0] pw;
    logic [5:0]  c7_reg;
    logic [13:0] wq7_reg;
    logic [2:0]  dplo7_reg;
    logic [10:0] dclo7_reg;
    logic [4:0]  hr7_reg;
    logic [5:0]  min7_reg;
    logic [5:0]  sec7_reg;
    logic [10:0] r8_reg;
    logic [5:0]  c8_reg;
    logic [2:0]  wd8_reg;
    logic [4:0]  hr8_reg;
    logic [5:0]  min8_reg;
    logic [5:0]  sec8_reg;
    logic [1:0]  yi;
    logic [8:0]  doy;
    logic [11:0] year9_reg;
    logic [8:0]  doy9_reg;
    logic        leap9_reg;
    logic [2:0]  wd9_reg;
    logic [4:0]  hr9_reg;
    logic [5:0]  min9_reg;
    logic [5:0]  sec9_reg;
    logic [3:0]  mon_next;
    logic [8:0]  mstart;
    logic [11:0] year10_reg;
    logic [3:0]  mon10_reg;
    logic [4:0]  day10_reg;
    logic [2:0]  wd10_reg;
    logic [4:0]  hr10_reg;
    logic [5:0]  min10_reg;
    logic [5:0]  sec10_reg;

    // stage 1: seconds / 60
    assign p1 = 64'(epoch_seconds) * 64'(MAG_DIV60);

    always_ff @(posedge aclk) begin
        if (en) begin
            q1_reg   <= p1[63:37];
            tlo1_reg <= epoch_seconds[5:0];
        end
    end

    // stage 2: second field from the remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_2_reg <= q1_reg;
            sec2_reg <= tlo1_reg - 6'(q1_reg * 27'd60);
        end
    end

    // stage 3: minutes / 60
    assign p3 = 64'(t1_2_reg) * 64'(MAG_DIV60);

    always_ff @(posedge aclk) begin
        if (en) begin
            q3_reg    <= p3[57:37];
            t1lo3_reg <= t1_2_reg[5:0];
            sec3_reg  <= sec2_reg;
        end
    end

    // stage 4: minute field
    always_ff @(posedge aclk) begin
        if (en) begin
            t2_4_reg <= q3_reg;
            min4_reg <= t1lo3_reg - 6'(q3_reg * 21'd60);
            sec4_reg <= sec3_reg;
        end
    end

    // stage 5: hours / 24
    assign p5 = 53'(t2_4_reg) * 53'(MAG_DIV3);

    always_ff @(posedge aclk) begin
        if (en) begin
            q5_reg    <= p5[51:36];
            t2lo5_reg <= t2_4_reg[4:0];
            min5_reg  <= min4_reg;
            sec5_reg  <= sec4_reg;
        end
    end

    // stage 6: hour field, day count on the 4-year cycle grid
    always_ff @(posedge aclk) begin
        if (en) begin
            days6_reg <= q5_reg;
            hr6_reg   <= t2lo5_reg - 5'(q5_reg * 16'd24);
            dc6_reg   <= q5_reg + CYCLE_OFFSET
                       + 16'((q5_reg >= SKIP_LEAP_DAY) ? 1 : 0);
            min6_reg  <= min5_reg;
            sec6_reg  <= sec5_reg;
        end
    end

    // stage 7: cycle and weekday quotients
    assign dp3 = days6_reg + 16'd3;
    assign pc  = 32'(dc6_reg) * 32'(MAG_DIV1461);
    assign pw  = 33'(dp3) * 33'(MAG_DIV7);

    always_ff @(posedge aclk) begin
        if (en) begin
            c7_reg    <= pc[31:26];
            wq7_reg   <= pw[32:19];
            dplo7_reg <= dp3[2:0];
            dclo7_reg <= dc6_reg[10:0];
            hr7_reg   <= hr6_reg;
            min7_reg  <= min6_reg;
            sec7_reg  <= sec6_reg;
        end
    end

    // stage 8: day within cycle and weekday
    always_ff @(posedge aclk) begin
        if (en) begin
            r8_reg   <= dclo7_reg - 11'(c7_reg * 6'd0 + 11'(c7_reg) * 11'd1461);
            wd8_reg  <= dplo7_reg - 3'(wq7_reg * 14'd7);
            c8_reg   <= c7_reg;
            hr8_reg  <= hr7_reg;
            min8_reg <= min7_reg;
            sec8_reg <= sec7_reg;
        end
    end

    // stage 9: year within cycle and day of year
    always_comb begin
        if (r8_reg < 11'd366) begin
            yi  = 2'd0;
            doy = 9'(r8_reg);
        end else if (r8_reg < 11'd731) begin
            yi  = 2'd1;
            doy = 9'(r8_reg - 11'd366);
        end else if (r8_reg < 11'd1096) begin
            yi  = 2'd2;
            doy = 9'(r8_reg - 11'd731);
        end else begin
            yi  = 2'd3;
            doy = 9'(r8_reg - 11'd1096);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year9_reg <= CYCLE_YEAR + {4'd0, c8_reg, 2'd0} + 12'(yi);
            doy9_reg  <= doy;
            leap9_reg <= (yi == 2'd0);
            wd9_reg   <= wd8_reg;
            hr9_reg   <= hr8_reg;
            min9_reg  <= min8_reg;
            sec9_reg  <= sec8_reg;
        end
    end

    // stage 10: month by threshold compares, then day of month
    always_comb begin
        mon_next = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (doy9_reg >= cum_days(4'(k)) + 9'((leap9_reg && k > 2) ? 1 : 0)) begin
                mon_next = mon_next + 4'd1;
            end
        end
        mstart = cum_days(mon_next) + 9'((leap9_reg && mon_next > 4'd2) ? 1 : 0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            year10_reg <= year9_reg;
            mon10_reg  <= mon_next;
            day10_reg  <= 5'(doy9_reg - mstart + 9'd1);
            wd10_reg   <= wd9_reg;
            hr10_reg   <= hr9_reg;
            min10_reg  <= min9_reg;
            sec10_reg  <= sec9_reg;
        end
    end

    assign year    = year10_reg;
    assign month   = mon10_reg;
    assign day     = day10_reg;
    assign hour    = hr10_reg;
    assign minute  = min10_reg;
    assign second  = sec10_reg;
    assign weekday = wd10_reg;

endmodule

// ===== sv/unix_time_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// unix_time_calendar_converter: unix seconds <-> gregorian utc date-time
// Two parallel datapaths share one valid pipeline; cmd picks the result.
// ----------------------------------------------------------------------------
//  channel   ports                                      direction
//  s_        s_valid s_ready s_cmd s_epoch_seconds s_cal_*   in
//  m_        m_valid m_ready m_out_*                    out
//
//  a beat enters every cycle while s_ready is high and passes through the
//  ten register stages of the seconds-to-date datapath to the result.
//  synchronous active-low reset clears only the stage valid bits.
//  a held result stalls the whole pipeline; s_ready falls only when the
//  last stage holds a beat that m_ready does not take.
// ----------------------------------------------------------------------------
module unix_time_calendar_converter
    import ucc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [31:0] s_epoch_seconds,
    input  logic [11:0] s_cal_year,
    input  logic [3:0]  s_cal_month,
    input  logic [4:0]  s_cal_day,
    input  logic [4:0]  s_cal_hour,
    input  logic [5:0]  s_cal_minute,
    input  logic [5:0]  s_cal_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_seconds,
    output logic [11:0] m_out_year,
    output logic [3:0]  m_out_month,
    output logic [4:0]  m_out_day,
    output logic [4:0]  m_out_hour,
    output logic [5:0]  m_out_minute,
    output logic [5:0]  m_out_second,
    output logic [2:0]  m_out_weekday
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    cmd_t                  cmd_reg [PIPE_DEPTH];
    logic                  to_date;
    logic [31:0] res_seconds;
    logic [11:0] res_year;
    logic [3:0]  res_month;
    logic [4:0]  res_day;
    logic [4:0]  res_hour;
    logic [5:0]  res_minute;
    logic [5:0]  res_second;
    logic [2:0]  res_weekday;

    // whole pipeline advances unless the last beat is held
    assign en      = !valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = en;

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], s_valid};

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    // command travels with the beat
    always_ff @(posedge aclk) begin
        if (en) begin
            cmd_reg[0] <= cmd_t'(s_cmd);
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                cmd_reg[i] <= cmd_reg[i-1];
            end
        end
    end

    ucc_to_seconds u_to_seconds (
        .aclk       (aclk),
        .en         (en),
        .cal_year   (s_cal_year),
        .cal_month  (s_cal_month),
        .cal_day    (s_cal_day),
        .cal_hour   (s_cal_hour),
        .cal_minute (s_cal_minute),
        .cal_second (s_cal_second),
        .seconds    (res_seconds)
    );

    ucc_to_date u_to_date (
        .aclk          (aclk),
        .en            (en),
        .epoch_seconds (s_epoch_seconds),
        .year          (res_year),
        .month         (res_month),
        .day           (res_day),
        .hour          (res_hour),
        .minute        (res_minute),
        .second        (res_second),
        .weekday       (res_weekday)
    );

    // result select, unused fields read zero
    assign to_date       = (cmd_reg[PIPE_DEPTH-1] == CMD_TO_DATE);
    assign m_valid       = valid_reg[PIPE_DEPTH-1];
    assign m_out_seconds = to_date ? 32'd0 : res_seconds;
    assign m_out_year    = to_date ? res_year    : 12'd0;
    assign m_out_month   = to_date ? res_month   : 4'd0;
    assign m_out_day     = to_date ? res_day     : 5'd0;
    assign m_out_hour    = to_date ? res_hour    : 5'd0;
    assign m_out_minute  = to_date ? res_minute  : 6'd0;
    assign m_out_second  = to_date ? res_second  : 6'd0;
    assign m_out_weekday = to_date ? res_weekday : 3'd0;

endmodule
